// ===== design/mcfs_pkg.sv =====
package mcfs_pkg;

  // Field widths of the streams
  localparam int CX_W     = 8;
  localparam int CY_W     = 7;
  localparam int RAD_W    = 5;
  localparam int XO_W     = 10;
  localparam int YO_W     = 9;
  localparam int KIND_W   = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Walk datapath widths
  localparam int ACC_W    = 22;
  localparam int ADD_W    = 24;
  localparam int SQ_W     = 2 * RAD_W;
  localparam int DX_W     = 6;
  localparam int DY_W     = 7;
  localparam int CNT_W    = 6;

  localparam int MAX_RADIUS_DEF = 31;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPAN   = 2'd0,
    KIND_CORNER = 2'd1,
    KIND_POINT  = 2'd2
  } kind_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQ   = 9'b000000010,
    S_SB   = 9'b000000100,
    S_DEC  = 9'b000001000,
    S_UA   = 9'b000010000,
    S_UB   = 9'b000100000,
    S_E1   = 9'b001000000,
    S_E2   = 9'b010000000,
    S_PUSH = 9'b100000000
  } state_t;

endpackage

// ===== design/midpoint_circle_fill_spans.sv =====
// Midpoint circle span generator. Each input word (center_x, center_y, radius)
// starts a walk of the midpoint ellipse algorithm with equal axes, from the top
// of the circle (offset x 0, offset y radius) down to offset y below zero. Each
// pass emits one output word: kind 0 is a pair of horizontal spans
// x_left..x_right on rows y_top and y_bottom, kind 1 is the four corner points
// when the row repeats, kind 2 is a single point for a radius of 0 or 1.
// tlast marks the final word of a circle; a walk stops at 64 words at most.
// Coordinates are raw signed values with no wrapping. A radius above MAX_RADIUS
// is saturated. The block takes one circle at a time and drops s_axis_tready
// until its last word is loaded into the output register. Setup runs S_SQ and
// S_SB (two registered multiplies for r*r and r*r*(2r+1)); each pass then runs
// S_DEC, then S_UA and S_E1 for a horizontal step, S_UB and S_E2 for a
// vertical step or all four for a diagonal step, then S_PUSH, since one shared
// 24-bit adder performs the decision sum and each accumulator update in turn.
// A circle of radius r makes at most 2r+1 passes. A radius of 0 or 1 skips
// setup and goes straight to the push step. A stalled master side stalls the
// walk at its push step.
module midpoint_circle_fill_spans #(
  parameter int MAX_RADIUS = mcfs_pkg::MAX_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // center_x [7:0], center_y [14:8], radius [19:15], zero [23:20]
  input  logic [mcfs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // x_left [9:0], x_right [19:10], y_top [28:20], y_bottom [37:29], zero [39:38]
  output logic [mcfs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // kind [1:0]
  output logic [mcfs_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                                m_axis_tlast
);
  import mcfs_pkg::*;

  state_t state, state_next;

  // Circle parameters held for the whole walk
  logic [CX_W-1:0]   cx;
  logic [CY_W-1:0]   cy;
  logic [RAD_W-1:0]  rad;
  logic [SQ_W-1:0]   sq;

  // Walk state
  logic [DX_W-1:0]          dx;
  logic signed [DY_W-1:0]   dy;
  logic signed [ACC_W-1:0]  step_a_accum;
  logic signed [ACC_W-1:0]  step_b_accum;
  logic signed [ACC_W-1:0]  error_term;
  logic [CNT_W-1:0]         n;
  logic                     prev_horiz;
  logic                     single;

  // Step chosen in the decision cycle
  logic step_x, step_y;

  // Word being built for the current pass
  logic [DX_W-1:0]   pend_dx;
  logic [DX_W-1:0]   pend_dy;
  kind_t             pend_kind;

  // Output register
  logic                  out_valid;
  logic [XO_W-1:0]       out_xl, out_xr;
  logic [YO_W-1:0]       out_yt, out_yb;
  kind_t                 out_kind;
  logic                  out_last;

  // Input unpacking
  logic [CX_W-1:0]  in_cx;
  logic [CY_W-1:0]  in_cy;
  logic [RAD_W-1:0] in_rad;
  logic [RAD_W-1:0] rad_sat;
  logic             in_small;
  logic             in_accept;

  assign in_cx  = s_axis_tdata[CX_W-1:0];
  assign in_cy  = s_axis_tdata[CX_W+CY_W-1:CX_W];
  assign in_rad = s_axis_tdata[CX_W+CY_W+RAD_W-1:CX_W+CY_W];
  assign rad_sat = (int'(in_rad) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : in_rad;
  assign in_small = (rad_sat <= RAD_W'(1));

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Shared adder: decision sum and all accumulator updates
  logic signed [ADD_W-1:0] add_a, add_b, add_sum;
  logic                    add_sub;
  logic signed [ADD_W-1:0] err_x2, sa_ext, sb_ext, e_ext, twosq_ext;

  assign err_x2    = {error_term[ACC_W-1], error_term, 1'b0};
  assign e_ext     = {{(ADD_W-ACC_W){error_term[ACC_W-1]}}, error_term};
  assign sa_ext    = {{(ADD_W-ACC_W){step_a_accum[ACC_W-1]}}, step_a_accum};
  assign sb_ext    = {{(ADD_W-ACC_W){step_b_accum[ACC_W-1]}}, step_b_accum};
  assign twosq_ext = {{(ADD_W-SQ_W-1){1'b0}}, sq, 1'b0};

  always_comb begin
    add_a   = e_ext;
    add_b   = sa_ext;
    add_sub = 1'b0;
    unique case (state)
      S_DEC: begin
        add_a   = err_x2;
        add_b   = error_term[ACC_W-1] ? sb_ext : sa_ext;
        add_sub = !error_term[ACC_W-1];
      end
      S_UA: begin
        add_a = sa_ext;
        add_b = twosq_ext;
      end
      S_UB: begin
        add_a   = sb_ext;
        add_b   = twosq_ext;
        add_sub = 1'b1;
      end
      S_E1: begin
        add_a = e_ext;
        add_b = sa_ext;
      end
      S_E2: begin
        add_a   = e_ext;
        add_b   = sb_ext;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = e_ext;
        add_b   = sa_ext;
        add_sub = 1'b0;
      end
    endcase
    add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  // Step decision from the error term and the decision sum
  logic err_neg, err_zero, sum_pos;
  logic dec_diag, dec_horiz, dec_x, dec_y;

  assign err_neg   = error_term[ACC_W-1];
  assign err_zero  = (error_term == '0);
  assign sum_pos   = !add_sum[ADD_W-1] && (add_sum != '0);
  assign dec_diag  = err_neg ? sum_pos : (err_zero || !sum_pos);
  assign dec_horiz = err_neg && !sum_pos;
  assign dec_x     = dec_diag || dec_horiz;
  assign dec_y     = !dec_horiz;

  logic out_free;
  assign out_free = !out_valid || m_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_accept) state_next = in_small ? S_PUSH : S_SQ;
      S_SQ:   state_next = S_SB;
      S_SB:   state_next = S_DEC;
      S_DEC:  state_next = dec_x ? S_UA : S_UB;
      S_UA:   state_next = step_y ? S_UB : S_E1;
      S_UB:   state_next = step_x ? S_E1 : S_E2;
      S_E1:   state_next = step_y ? S_E2 : S_PUSH;
      S_E2:   state_next = S_PUSH;
      S_PUSH: begin
        if (out_free) begin
          if (single || dy[DY_W-1] || (n == '1)) state_next = S_IDLE;
          else state_next = S_DEC;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          cx        <= in_cx;
          cy        <= in_cy;
          rad       <= rad_sat;
          single    <= in_small;
          pend_dx   <= '0;
          pend_dy   <= '0;
          pend_kind <= KIND_POINT;
          dy        <= '0;
          n         <= '0;
        end
      end
      S_SQ: begin
        sq           <= SQ_W'(rad) * SQ_W'(rad);
        dx           <= '0;
        dy           <= DY_W'(rad);
        n            <= '0;
        prev_horiz   <= 1'b0;
        error_term   <= ACC_W'(2) - ACC_W'({rad, 1'b0});
      end
      S_SB: begin
        step_a_accum <= ACC_W'(sq);
        step_b_accum <= ACC_W'(sq) * ACC_W'({rad, 1'b1});
      end
      S_DEC: begin
        pend_dx    <= dx;
        pend_dy    <= dy[DX_W-1:0];
        pend_kind  <= prev_horiz ? KIND_CORNER : KIND_SPAN;
        prev_horiz <= dec_horiz;
        step_x     <= dec_x;
        step_y     <= dec_y;
        if (dec_x) dx <= dx + DX_W'(1);
        if (dec_y) dy <= dy - DY_W'(1);
      end
      S_UA: step_a_accum <= add_sum[ACC_W-1:0];
      S_UB: step_b_accum <= add_sum[ACC_W-1:0];
      S_E1: error_term   <= add_sum[ACC_W-1:0];
      S_E2: error_term   <= add_sum[ACC_W-1:0];
      S_PUSH: begin
        if (out_free) n <= n + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register: load on push, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_PUSH) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_PUSH) && out_free) begin
      out_xl   <= XO_W'({2'b00, cx}) - XO_W'(pend_dx);
      out_xr   <= XO_W'({2'b00, cx}) + XO_W'(pend_dx);
      out_yt   <= YO_W'({2'b00, cy}) - YO_W'(pend_dy);
      out_yb   <= YO_W'({2'b00, cy}) + YO_W'(pend_dy);
      out_kind <= pend_kind;
      out_last <= single || dy[DY_W-1] || (n == '1);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_yb, out_yt, out_xr, out_xl};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

// ===== design/mcfs_checker.sv =====
module mcfs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [mcfs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mcfs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [mcfs_pkg::KIND_W-1:0]       m_axis_tuser,
  input logic                              m_axis_tlast
);
  import mcfs_pkg::*;

  // One circle at a time: no new word right after one is taken
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while walk in progress");

  // Stalled output word holds
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output word changed under stall");

  // Single point closes its circle and has no extent
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_POINT)) |->
      (m_axis_tlast && (m_axis_tdata[9:0] == m_axis_tdata[19:10])
       && (m_axis_tdata[28:20] == m_axis_tdata[37:29])))
    else $error("single point word malformed");

  // Spans never run backward
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[19:10]) >= $signed(m_axis_tdata[9:0])
       && $signed(m_axis_tdata[37:29]) >= $signed(m_axis_tdata[28:20])))
    else $error("span endpoints out of order");

endmodule

bind midpoint_circle_fill_spans mcfs_checker u_mcfs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
